FILE: sv/assert_macros.svh
// Assertion macros used by clns_ctrl.
// Needs nothing else; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CLNS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CLNS_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define CLNS_ASSERT(label, clk, rst, prop, msg)
`define CLNS_NEVER(label, clk, rst, cond, msg)
`endif
`endif

FILE: sv/clns_pkg.sv
// Types, codes and the power-on table of the LCD nibble sequencer.
// Used by clns_ctrl, clns_dp and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package clns_pkg;

   typedef enum logic [2:0] {
      OP_INIT   = 3'd0,
      OP_DATA   = 3'd1,
      OP_INSTR  = 3'd2,
      OP_LOCATE = 3'd3,
      OP_CLEAR  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INIT,
      ST_HIGH,
      ST_LOW
   } state_type;

   typedef enum logic [1:0] {
      SEL_INIT,
      SEL_HIGH,
      SEL_LOW
   } sel_type;

   localparam logic [3:0]  InitLast   = 4'd12;
   localparam logic [13:0] WaitLocate = 14'd35;
   localparam logic [13:0] WaitClear  = 14'd2000;
   localparam logic [7:0]  CmdLocate  = 8'h80;
   localparam logic [7:0]  CmdClear   = 8'h01;

   typedef struct packed {
      logic        rs;
      logic        strobe;
      logic [3:0]  nibble;
      logic [13:0] wait_us;
      logic        last;
   } transfer_type;

   typedef struct packed {
      logic       accept;
      logic       emit;
      sel_type    sel;
      logic [3:0] init_idx;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
   } sts_type;

   // power-on run: settle, 3,3,3,2, then 0x28, 0x06, 0x0C, 0x01 as nibble pairs
   function automatic transfer_type init_entry(input logic [3:0] idx);
      transfer_type t;
      t = '{rs: 1'b0, strobe: 1'b1, nibble: 4'h0, wait_us: 14'd0, last: 1'b0};
      case (idx)
         4'd0: begin
            t.strobe  = 1'b0;
            t.wait_us = 14'd15000;
         end
         4'd1: begin
            t.nibble  = 4'h3;
            t.wait_us = 14'd4000;
         end
         4'd2, 4'd3: begin
            t.nibble  = 4'h3;
            t.wait_us = 14'd2000;
         end
         4'd4: begin
            t.nibble  = 4'h2;
            t.wait_us = 14'd1000;
         end
         4'd5:  t.nibble = 4'h2;
         4'd6: begin
            t.nibble  = 4'h8;
            t.wait_us = 14'd1000;
         end
         4'd7:  t.nibble = 4'h0;
         4'd8: begin
            t.nibble  = 4'h6;
            t.wait_us = 14'd1000;
         end
         4'd9:  t.nibble = 4'h0;
         4'd10: begin
            t.nibble  = 4'hC;
            t.wait_us = 14'd1000;
         end
         4'd11: t.nibble = 4'h0;
         4'd12: begin
            t.nibble  = 4'h1;
            t.wait_us = 14'd2000;
            t.last    = 1'b1;
         end
         default: t = '{rs: 1'b0, strobe: 1'b0, nibble: 4'h0, wait_us: 14'd0, last: 1'b0};
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

FILE: sv/clns_dp.sv
// Datapath: request holding registers, transfer builder and output register.
// Depends on clns_pkg; driven by commands from clns_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module clns_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire clns_pkg::cmd_type cmd,
   output clns_pkg::sts_type      sts,
   input  wire logic [2:0]        req_operation,
   input  wire logic [7:0]        req_byte_value,
   input  wire logic              req_row,
   input  wire logic [5:0]        req_col,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_register_select,
   output logic                   rsp_strobe_res,
   output logic [3:0]             rsp_nibble,
   output logic [13:0]            rsp_wait_us,
   output logic                   rsp_last
);

   logic                   rs_ff, rs_in;
   logic [7:0]             byte_ff, byte_in;
   logic [13:0]            wait_ff, wait_in;
   logic                   valid_ff, valid_in;
   clns_pkg::transfer_type out_ff, out_in;
   clns_pkg::op_type       op;

   assign op            = clns_pkg::op_type'(req_operation);
   assign sts.slot_free = !valid_ff || !rsp_stall;

   always_comb begin
      rs_in   = rs_ff;
      byte_in = byte_ff;
      wait_in = wait_ff;
      if (cmd.accept) begin
         rs_in   = (op == clns_pkg::OP_DATA);
         byte_in = req_byte_value;
         wait_in = 14'd0;
         case (op)
            clns_pkg::OP_LOCATE: begin
               byte_in = clns_pkg::CmdLocate + {1'b0, req_row, 6'b0} + {2'b00, req_col};
               wait_in = clns_pkg::WaitLocate;
            end
            clns_pkg::OP_CLEAR: begin
               byte_in = clns_pkg::CmdClear;
               wait_in = clns_pkg::WaitClear;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      out_in   = out_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         case (cmd.sel)
            clns_pkg::SEL_INIT: out_in = clns_pkg::init_entry(cmd.init_idx);
            clns_pkg::SEL_HIGH: out_in = '{rs: rs_ff, strobe: 1'b1, nibble: byte_ff[7:4],
                                           wait_us: 14'd0, last: 1'b0};
            clns_pkg::SEL_LOW:  out_in = '{rs: rs_ff, strobe: 1'b1, nibble: byte_ff[3:0],
                                           wait_us: wait_ff, last: 1'b1};
            default:            out_in = out_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rs_ff   <= rs_in;
      byte_ff <= byte_in;
      wait_ff <= wait_in;
      out_ff  <= out_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_register_select = out_ff.rs;
   assign rsp_strobe_res      = out_ff.strobe;
   assign rsp_nibble          = out_ff.nibble;
   assign rsp_wait_us         = out_ff.wait_us;
   assign rsp_last            = out_ff.last;

endmodule

`default_nettype wire

FILE: sv/clns_ctrl.sv
// Controller: sequences the transfers of one request and paces the handshakes.
// Depends on clns_pkg and assert_macros.svh; commands clns_dp.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module clns_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [2:0]        req_operation,
   input  wire clns_pkg::sts_type sts,
   output clns_pkg::cmd_type      cmd
);

   clns_pkg::state_type state_ff, state_in;
   logic [3:0]          step_ff, step_in;
   logic                ready;
   logic                last_emit;
   clns_pkg::op_type    op;

   assign op = clns_pkg::op_type'(req_operation);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clns_pkg::ST_IDLE;
         step_ff  <= 4'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      ready        = 1'b0;
      last_emit    = 1'b0;
      cmd.accept   = 1'b0;
      cmd.emit     = 1'b0;
      cmd.sel      = clns_pkg::SEL_INIT;
      cmd.init_idx = step_ff;
      case (state_ff)
         clns_pkg::ST_IDLE: ready = 1'b1;
         clns_pkg::ST_HIGH: begin
            if (sts.slot_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = clns_pkg::SEL_HIGH;
               state_in = clns_pkg::ST_LOW;
            end
         end
         clns_pkg::ST_LOW: begin
            if (sts.slot_free) begin
               cmd.emit  = 1'b1;
               cmd.sel   = clns_pkg::SEL_LOW;
               last_emit = 1'b1;
               ready     = 1'b1;
               state_in  = clns_pkg::ST_IDLE;
            end
         end
         clns_pkg::ST_INIT: begin
            if (sts.slot_free) begin
               cmd.emit = 1'b1;
               if (step_ff == clns_pkg::InitLast) begin
                  last_emit = 1'b1;
                  ready     = 1'b1;
                  state_in  = clns_pkg::ST_IDLE;
               end else begin
                  step_in = step_ff + 4'd1;
               end
            end
         end
         default: state_in = clns_pkg::ST_IDLE;
      endcase
      // take the next request when idle or in the cycle the final transfer is emitted
      if (ready && req_valid) begin
         cmd.accept = 1'b1;
         if (op == clns_pkg::OP_INIT) begin
            state_in = clns_pkg::ST_INIT;
            step_in  = 4'd0;
         end else if (op inside {clns_pkg::OP_DATA, clns_pkg::OP_INSTR,
                                 clns_pkg::OP_LOCATE, clns_pkg::OP_CLEAR}) begin
            state_in = clns_pkg::ST_HIGH;
         end
      end
   end

   assign req_stall = !ready;

   `CLNS_ASSERT(a_emit_free, clock, reset, cmd.emit |-> sts.slot_free, "emit into busy slot")
   `CLNS_ASSERT(a_accept_end, clock, reset,
                (req_valid && !req_stall) |-> (state_ff == clns_pkg::ST_IDLE || last_emit),
                "accept mid-run")
   `CLNS_ASSERT(a_step_range, clock, reset,
                (state_ff == clns_pkg::ST_INIT) |-> (step_ff <= clns_pkg::InitLast),
                "init step out of range")
   `CLNS_ASSERT(a_high_low, clock, reset,
                (state_ff == clns_pkg::ST_HIGH && cmd.emit) |=> (state_ff == clns_pkg::ST_LOW),
                "high nibble not followed by low")

endmodule

`default_nettype wire

FILE: sv/char_lcd_nibble_sequencer_core.sv
// Turns LCD requests (init, data, instruction, locate, clear) into nibble
// transfers for a 4-bit character LCD bus: one transfer per cycle out of a single
// output register while rsp_stall does not hold it, so data, instruction, locate
// and clear give 2 transfers, init gives 13, and codes 5 to 7 are dropped. A new
// request is taken in the cycle the previous request's final transfer is loaded.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_sequencer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_operation,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic        req_row,
   input  wire logic [5:0]  req_col,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_register_select,
   output logic             rsp_strobe_res,
   output logic [3:0]       rsp_nibble,
   output logic [13:0]      rsp_wait_us,
   output logic             rsp_last
);

   clns_pkg::cmd_type cmd;
   clns_pkg::sts_type sts;

   clns_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .sts           (sts),
      .cmd           (cmd)
   );

   clns_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_operation       (req_operation),
      .req_byte_value      (req_byte_value),
      .req_row             (req_row),
      .req_col             (req_col),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_register_select (rsp_register_select),
      .rsp_strobe_res      (rsp_strobe_res),
      .rsp_nibble          (rsp_nibble),
      .rsp_wait_us         (rsp_wait_us),
      .rsp_last            (rsp_last)
   );

endmodule

`default_nettype wire
